// ----- rtl/crd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crd_pkg
// shared widths, reset values, register indexes, port codes and select config for the circulant router
// ----------------------------------------------------------------------------
package crd_pkg;

   localparam int NodeWidth   = 10;
   localparam int RegWidth    = 11;
   localparam int OffsetWidth = 13;
   localparam int CsrIdxWidth = 2;
   localparam int DivSteps    = 2;

   localparam logic [RegWidth-1:0] MaxNodes = 11'd1024;

   localparam logic [RegWidth-1:0] NodeCountReset     = 11'd16;
   localparam logic [RegWidth-1:0] GeneratorAReset    = 11'd4;
   localparam logic [RegWidth-1:0] GeneratorBReset    = 11'd4;
   localparam logic [RegWidth-1:0] DiameterBoundReset = 11'd2;

   typedef enum logic [CsrIdxWidth-1:0] {
      CsrNodeCount     = 2'd0,
      CsrGeneratorA    = 2'd1,
      CsrGeneratorB    = 2'd2,
      CsrDiameterBound = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      PortNorth = 3'd0,
      PortEast  = 3'd1,
      PortSouth = 3'd2,
      PortWest  = 3'd3,
      PortLocal = 3'd4
   } port_type;

   typedef struct packed {
      logic [RegWidth-1:0] gen_a;
      logic [RegWidth-1:0] gen_b;
      logic [RegWidth-1:0] bound;
   } sel_cfg_type;

endpackage

`default_nettype wire

// ----- rtl/crd_divider.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crd_divider
// pipelined restoring divider, Steps quotient bits per stage
// ----------------------------------------------------------------------------
module crd_divider #(
   parameter int Width     = crd_pkg::NodeWidth,
   parameter int DivWidth  = crd_pkg::RegWidth,
   parameter int Steps     = crd_pkg::DivSteps,
   parameter int SideWidth = 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output      logic                 in_ready,
   input  wire logic [Width-1:0]     in_dividend,
   input  wire logic [SideWidth-1:0] in_side,
   input  wire logic [DivWidth-1:0]  divisor,
   output      logic                 out_valid,
   input  wire logic                 out_ready,
   output      logic [Width-1:0]     out_quotient,
   output      logic [DivWidth-1:0]  out_remainder,
   output      logic [SideWidth-1:0] out_side
);

   localparam int Stages = Width / Steps;

   logic [Stages-1:0]    vld_ff;
   logic [DivWidth-1:0]  rem_ff  [Stages];
   logic [Width-1:0]     quo_ff  [Stages];
   logic [SideWidth-1:0] side_ff [Stages];
   logic [Stages:0]      rdy;

   assign rdy[Stages] = out_ready;
   assign in_ready    = rdy[0];

   for (genvar s = 0; s < Stages; s++) begin : g_stage
      logic                 src_vld;
      logic [DivWidth-1:0]  src_rem;
      logic [Width-1:0]     src_quo;
      logic [SideWidth-1:0] src_side;
      logic [DivWidth-1:0]  rem_in;
      logic [Width-1:0]     quo_in;

      if (s == 0) begin : g_first
         assign src_vld  = in_valid;
         assign src_rem  = '0;
         assign src_quo  = in_dividend;
         assign src_side = in_side;
      end else begin : g_next
         assign src_vld  = vld_ff[s-1];
         assign src_rem  = rem_ff[s-1];
         assign src_quo  = quo_ff[s-1];
         assign src_side = side_ff[s-1];
      end

      always_comb begin
         logic [DivWidth:0]   t;
         logic [DivWidth-1:0] r;
         logic [Width-1:0]    q;
         r = src_rem;
         q = src_quo;
         for (int k = 0; k < Steps; k++) begin
            t = {r, q[Width-1]};
            q = {q[Width-2:0], 1'b0};
            if (t >= {1'b0, divisor}) begin
               t    = t - {1'b0, divisor};
               q[0] = 1'b1;
            end
            r = t[DivWidth-1:0];
         end
         rem_in = r;
         quo_in = q;
      end

      assign rdy[s] = !vld_ff[s] || rdy[s+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            vld_ff[s] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[s] && src_vld) begin
            rem_ff[s]  <= rem_in;
            quo_ff[s]  <= quo_in;
            side_ff[s] <= src_side;
         end
      end
   end

   assign out_valid     = vld_ff[Stages-1];
   assign out_quotient  = quo_ff[Stages-1];
   assign out_remainder = rem_ff[Stages-1];
   assign out_side      = side_ff[Stages-1];

endmodule

`default_nettype wire

// ----- rtl/crd_select.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// crd_select
// second coordinate, nearest zero vector choice, port and cost, three stages
// ----------------------------------------------------------------------------
module crd_select (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire crd_pkg::sel_cfg_type           cfg,
   input  wire logic                           in_valid,
   output      logic                           in_ready,
   input  wire logic [crd_pkg::NodeWidth-1:0]  in_quotient,
   input  wire logic [crd_pkg::NodeWidth-1:0]  in_remainder,
   output      logic                           out_valid,
   input  wire logic                           out_ready,
   output      crd_pkg::port_type              out_port,
   output      logic signed [crd_pkg::OffsetWidth-1:0] out_offset_first,
   output      logic signed [crd_pkg::OffsetWidth-1:0] out_offset_second,
   output      logic [crd_pkg::OffsetWidth-1:0] out_cost
);
   import crd_pkg::*;

   // stage y
   logic                  y_vld_ff;
   logic [NodeWidth-1:0]  xv_ff;
   logic [RegWidth-1:0]   yv_ff;
   logic [RegWidth-1:0]   yv_in;
   logic                  y_rdy;

   // stage p
   logic                          p_vld_ff;
   logic signed [OffsetWidth-1:0] p1_ff, p2_ff;
   logic signed [OffsetWidth-1:0] p1_in, p2_in;
   logic                          p_rdy;

   // stage o
   logic                          o_vld_ff;
   port_type                      port_ff, port_in;
   logic signed [OffsetWidth-1:0] o1_ff, o2_ff;
   logic [OffsetWidth-1:0]        cost_ff, cost_in;
   logic                          o_rdy;

   assign o_rdy    = !o_vld_ff || out_ready;
   assign p_rdy    = !p_vld_ff || o_rdy;
   assign y_rdy    = !y_vld_ff || p_rdy;
   assign in_ready = y_rdy;

   // yv = (b odd ? q/2 : 0) + (q odd ? ceil(b/2) : 0)
   always_comb begin
      logic [RegWidth-1:0] odd_part;
      logic [RegWidth-1:0] half_part;
      logic [RegWidth-1:0] hb;
      hb        = {1'b0, cfg.gen_b[RegWidth-1:1]} + RegWidth'(cfg.gen_b[0]);
      odd_part  = cfg.gen_b[0] ? {2'b0, in_quotient[NodeWidth-1:1]} : '0;
      half_part = in_quotient[0] ? hb : '0;
      yv_in     = odd_part + half_part;
   end

   always_comb begin
      logic [RegWidth:0]      hb;
      logic [RegWidth:0]      sum_xy;
      logic [RegWidth+1:0]    lhs, rhs;
      logic                   case_one, case_two, low_y;
      logic signed [OffsetWidth-1:0] xs, ys;
      hb       = ({1'b0, cfg.gen_b} + 12'd1) >> 1;
      low_y    = {1'b0, yv_ff} < hb;
      sum_xy   = {2'b0, xv_ff} + {1'b0, yv_ff};
      case_one = low_y && (sum_xy <= {1'b0, cfg.bound});
      lhs      = {2'b0, yv_ff} + {2'b0, cfg.bound};
      rhs      = {2'b0, cfg.gen_b} + {3'b0, xv_ff};
      case_two = !low_y && (lhs >= rhs);
      xs       = $signed({3'b0, xv_ff});
      ys       = $signed({2'b0, yv_ff});
      if (case_one) begin
         p1_in = xs;
         p2_in = ys;
      end else if (case_two) begin
         p1_in = xs;
         p2_in = ys - $signed({2'b0, cfg.gen_b});
      end else begin
         p1_in = xs - $signed({2'b0, cfg.gen_a});
         p2_in = ys - $signed({3'b0, cfg.gen_b[RegWidth-1:1]});
      end
   end

   always_comb begin
      logic [OffsetWidth-1:0] a1, a2;
      a1 = p1_ff[OffsetWidth-1] ? -p1_ff : p1_ff;
      a2 = p2_ff[OffsetWidth-1] ? -p2_ff : p2_ff;
      cost_in = a1 + a2;
      if (p1_ff > 0) begin
         port_in = PortSouth;
      end else if (p1_ff < 0) begin
         port_in = PortNorth;
      end else if (p2_ff > 0) begin
         port_in = PortEast;
      end else if (p2_ff < 0) begin
         port_in = PortWest;
      end else begin
         port_in = PortLocal;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         y_vld_ff <= 1'b0;
         p_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else begin
         if (y_rdy) begin
            y_vld_ff <= in_valid;
         end
         if (p_rdy) begin
            p_vld_ff <= y_vld_ff;
         end
         if (o_rdy) begin
            o_vld_ff <= p_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (y_rdy && in_valid) begin
         xv_ff <= in_remainder;
         yv_ff <= yv_in;
      end
      if (p_rdy && y_vld_ff) begin
         p1_ff <= p1_in;
         p2_ff <= p2_in;
      end
      if (o_rdy && p_vld_ff) begin
         port_ff <= port_in;
         o1_ff   <= p1_ff;
         o2_ff   <= p2_ff;
         cost_ff <= cost_in;
      end
   end

   assign out_valid         = o_vld_ff;
   assign out_port          = port_ff;
   assign out_offset_first  = o1_ff;
   assign out_offset_second = o2_ff;
   assign out_cost          = cost_ff;

endmodule

`default_nettype wire

// ----- rtl/circulant_route_direction_core.sv -----
`default_nettype none
// a request passes the entry register, modulo divider, v register, generator a divider and select stages
// throughput: one request per cycle while rsp_stall is low, set by the two divider pipelines
// each divider resolves two quotient bits per stage over five stages
// reset: synchronous active high; clears all valid bits and loads
// node_count 16, generator_a 4, generator_b 4, diameter_bound 2
// ----------------------------------------------------------------------------
// circulant_route_direction_core
// routing direction for a two-generator circulant network-on-chip
// ----------------------------------------------------------------------------
module circulant_route_direction_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write_enable,
   input  wire logic [crd_pkg::CsrIdxWidth-1:0]       csr_index,
   input  wire logic [crd_pkg::RegWidth-1:0]          csr_write_data,
   input  wire logic                                  req_valid,
   output      logic                                  req_stall,
   input  wire logic [crd_pkg::NodeWidth-1:0]         req_current_node,
   input  wire logic [crd_pkg::NodeWidth-1:0]         req_destination_node,
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   output      logic [2:0]                            rsp_first_port,
   output      logic signed [crd_pkg::OffsetWidth-1:0] rsp_offset_first,
   output      logic signed [crd_pkg::OffsetWidth-1:0] rsp_offset_second,
   output      logic [crd_pkg::OffsetWidth-1:0]       rsp_path_cost
);
   import crd_pkg::*;

   logic [RegWidth-1:0] node_count_ff, gen_a_ff, gen_b_ff, bound_ff;
   logic [RegWidth-1:0] n_eff, a_eff;
   sel_cfg_type         sel_cfg;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NodeCountReset;
         gen_a_ff      <= GeneratorAReset;
         gen_b_ff      <= GeneratorBReset;
         bound_ff      <= DiameterBoundReset;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CsrNodeCount:     node_count_ff <= csr_write_data;
            CsrGeneratorA:    gen_a_ff      <= csr_write_data;
            CsrGeneratorB:    gen_b_ff      <= csr_write_data;
            CsrDiameterBound: bound_ff      <= csr_write_data;
            default:          node_count_ff <= node_count_ff;
         endcase
      end
   end

   always_comb begin
      if (node_count_ff == '0) begin
         n_eff = RegWidth'(1);
      end else if (node_count_ff > MaxNodes) begin
         n_eff = MaxNodes;
      end else begin
         n_eff = node_count_ff;
      end
      a_eff = (gen_a_ff == '0) ? RegWidth'(1) : gen_a_ff;
   end

   assign sel_cfg = '{gen_a: a_eff, gen_b: gen_b_ff, bound: bound_ff};

   // entry stage: magnitude and sign of the node difference
   logic                 e_vld_ff, e_rdy;
   logic [NodeWidth-1:0] mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic                 d1_in_ready;

   always_comb begin
      logic [NodeWidth:0] diff;
      diff   = {1'b0, req_destination_node} - {1'b0, req_current_node};
      neg_in = diff[NodeWidth];
      mag_in = neg_in ? NodeWidth'(-diff) : diff[NodeWidth-1:0];
   end

   assign e_rdy     = !e_vld_ff || d1_in_ready;
   assign req_stall = !e_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (e_rdy) begin
         e_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (e_rdy && req_valid) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
   end

   // modulo node count
   logic                 d1_vld, d1_neg;
   logic [RegWidth-1:0]  d1_rem;
   logic                 v_vld_ff, v_rdy;
   logic [NodeWidth-1:0] v_ff, v_in;
   logic                 d2_in_ready;

   crd_divider #(
      .Width     (NodeWidth),
      .DivWidth  (RegWidth),
      .Steps     (DivSteps),
      .SideWidth (1)
   ) u_mod_n (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (e_vld_ff),
      .in_ready      (d1_in_ready),
      .in_dividend   (mag_ff),
      .in_side       (neg_ff),
      .divisor       (n_eff),
      .out_valid     (d1_vld),
      .out_ready     (v_rdy),
      .out_quotient  (),
      .out_remainder (d1_rem),
      .out_side      (d1_neg)
   );

   always_comb begin
      logic [RegWidth-1:0] wrap;
      wrap = n_eff - d1_rem;
      v_in = (d1_neg && d1_rem != '0) ? wrap[NodeWidth-1:0] : d1_rem[NodeWidth-1:0];
   end

   assign v_rdy = !v_vld_ff || d2_in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_vld_ff <= 1'b0;
      end else if (v_rdy) begin
         v_vld_ff <= d1_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (v_rdy && d1_vld) begin
         v_ff <= v_in;
      end
   end

   // split by generator a
   logic                 d2_vld, sel_in_ready;
   logic [NodeWidth-1:0] d2_quo;
   logic [RegWidth-1:0]  d2_rem;

   crd_divider #(
      .Width     (NodeWidth),
      .DivWidth  (RegWidth),
      .Steps     (DivSteps),
      .SideWidth (1)
   ) u_div_a (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (v_vld_ff),
      .in_ready      (d2_in_ready),
      .in_dividend   (v_ff),
      .in_side       (1'b0),
      .divisor       (a_eff),
      .out_valid     (d2_vld),
      .out_ready     (sel_in_ready),
      .out_quotient  (d2_quo),
      .out_remainder (d2_rem),
      .out_side      ()
   );

   port_type sel_port;

   crd_select u_select (
      .clock             (clock),
      .reset             (reset),
      .cfg               (sel_cfg),
      .in_valid          (d2_vld),
      .in_ready          (sel_in_ready),
      .in_quotient       (d2_quo),
      .in_remainder      (d2_rem[NodeWidth-1:0]),
      .out_valid         (rsp_valid),
      .out_ready         (!rsp_stall),
      .out_port          (sel_port),
      .out_offset_first  (rsp_offset_first),
      .out_offset_second (rsp_offset_second),
      .out_cost          (rsp_path_cost)
   );

   assign rsp_first_port = sel_port;

endmodule

`default_nettype wire
